// ===== hdl/lnbt_pkg.sv =====
`timescale 1ns / 1ps

package lnbt_pkg;

    localparam int FEAT_W     = 8;
    localparam int W_W        = 32;
    localparam int ACC_W      = 40;
    localparam int PROD_W     = 40;
    localparam int S_W        = 17;
    localparam int E_W        = 18;
    localparam int D_W        = 17;
    localparam int DELTA_W    = 18;
    localparam int LR_W       = 16;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int MAX_FEATURES = 3;

    localparam logic [LR_W-1:0] LR_RESET = 16'd3277;
    localparam logic [S_W-1:0]  ONE_Q16  = 17'h10000;

    // register index, taken from paddr[2]
    localparam logic REG_LR = 1'b0;

    localparam logic CMD_TRAIN   = 1'b0;
    localparam logic CMD_PREDICT = 1'b1;

    localparam logic [63:0] Q30_ONE = 64'd1 << 30;

    typedef logic signed [PROD_W-1:0] prod_t;

    typedef struct packed {
        logic mul_en;
        logic acc_en;
        logic upd_lo_en;
        logic upd_en;
    } lane_ctl_t;

    typedef struct packed {
        logic sum_en;
        logic idx_en;
        logic rom_en;
    } eval_ctl_t;

    typedef struct packed {
        logic err_en;
        logic delta_en;
    } grad_ctl_t;

    // elaboration-time helpers for building the sigmoid table
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        logic [63:0] rem;
        q   = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[62:0], num[b]};
            if (rem >= den) begin
                rem  = rem - den;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // e^-f, f in [0,1], Q2.30
    function automatic logic [63:0] exp_neg_frac(input logic [63:0] f);
        logic [63:0] term;
        longint      sum;
        term = Q30_ONE;
        sum  = longint'(Q30_ONE);
        for (int k = 1; k <= 14; k++) begin
            term = udiv64((term * f) >> 30, 64'(k));
            if ((k & 1) == 1) begin
                sum = sum - longint'(term);
            end else begin
                sum = sum + longint'(term);
            end
        end
        return (sum < 0) ? 64'd0 : 64'(sum);
    endfunction

    function automatic logic [S_W-1:0] sig_entry(input int unsigned idx,
                                                 input int unsigned depth);
        logic [63:0] e1;
        logic [63:0] u;
        logic [63:0] n;
        logic [63:0] r;
        logic [63:0] den;
        logic [63:0] num;
        logic [63:0] q;
        longint      a;
        e1 = exp_neg_frac(Q30_ONE);
        a  = longint'(udiv64(64'(idx) << 34, 64'(depth))) - (longint'(8) <<< 30);
        u  = (a < 0) ? 64'(-a) : 64'(a);
        n  = u >> 30;
        r  = exp_neg_frac(u & (Q30_ONE - 64'd1));
        for (int m = 0; m < 8; m++) begin
            if (64'(m) < n) begin
                r = (r * e1) >> 30;
            end
        end
        den = Q30_ONE + r;
        num = (a >= 0) ? (64'd1 << 46) : (r << 16);
        q   = udiv64(num + (den >> 1), den);
        return q[S_W-1:0];
    endfunction

endpackage

// ===== hdl/lnbt_lane.sv =====
`timescale 1ns / 1ps

module lnbt_lane import lnbt_pkg::*; (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  lane_ctl_t                 ctl,
    input  logic signed [FEAT_W-1:0]  x,
    input  logic signed [DELTA_W-1:0] delta,
    input  logic [LR_W-1:0]           lr,
    output prod_t                     prod,
    output logic signed [W_W-1:0]     weight
);

    localparam int DX_W  = DELTA_W + FEAT_W;
    localparam int HALF  = ACC_W / 2;
    localparam int PLO_W = LR_W + HALF;
    localparam int PHI_W = LR_W + 1 + (ACC_W - HALF);
    localparam int FULL_W = PHI_W + HALF;
    localparam int STEP_W = FULL_W - 16;
    localparam int DIFF_W = STEP_W + 1;

    logic signed [W_W-1:0]    weight_reg, weight_next;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    prod_t                    prod_reg;
    logic [PLO_W-1:0]         plo_reg;
    logic signed [PHI_W-1:0]  phi_reg;

    logic signed [DX_W-1:0]   dx;
    logic signed [ACC_W:0]    acc_sum;
    prod_t                    wx;
    logic [PLO_W-1:0]         plo_next;
    logic signed [PHI_W-1:0]  phi_next;
    logic signed [FULL_W-1:0] full;
    logic signed [STEP_W-1:0] step;
    logic signed [DIFF_W-1:0] diff;

    assign wx       = PROD_W'(weight_reg) * PROD_W'(x);
    assign dx       = DX_W'(delta) * DX_W'(x);
    assign acc_sum  = {acc_reg[ACC_W-1], acc_reg} + {{(ACC_W + 1 - DX_W){dx[DX_W-1]}}, dx};
    assign plo_next = PLO_W'(lr) * PLO_W'(acc_reg[HALF-1:0]);
    assign phi_next = PHI_W'($signed({1'b0, lr})) * PHI_W'($signed(acc_reg[ACC_W-1:HALF]));
    assign full     = {phi_reg, {HALF{1'b0}}} + $signed({{(FULL_W - PLO_W){1'b0}}, plo_reg});
    assign step     = full[FULL_W-1:16];
    assign diff     = {{(DIFF_W - W_W){weight_reg[W_W-1]}}, weight_reg} - {step[STEP_W-1], step};

    always_comb begin
        if (acc_sum[ACC_W] != acc_sum[ACC_W-1]) begin
            acc_next = acc_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end else begin
            acc_next = acc_sum[ACC_W-1:0];
        end
        if (diff[DIFF_W-1:W_W-1] != {(DIFF_W - W_W + 1){diff[DIFF_W-1]}}) begin
            weight_next = diff[DIFF_W-1] ? {1'b1, {(W_W-1){1'b0}}} : {1'b0, {(W_W-1){1'b1}}};
        end else begin
            weight_next = diff[W_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            weight_reg <= '0;
            acc_reg    <= '0;
        end else if (ctl.upd_en) begin
            weight_reg <= weight_next;
            acc_reg    <= '0;
        end else if (ctl.acc_en) begin
            acc_reg <= acc_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.mul_en) begin
            prod_reg <= wx;
        end
        if (ctl.upd_lo_en) begin
            plo_reg <= plo_next;
            phi_reg <= phi_next;
        end
    end

    assign prod   = prod_reg;
    assign weight = weight_reg;

endmodule

// ===== hdl/lnbt_eval.sv =====
`timescale 1ns / 1ps

module lnbt_eval import lnbt_pkg::*; #(
    parameter int NUM_LANES   = 4,
    parameter int TABLE_DEPTH = 256
) (
    input  logic           aclk,
    input  eval_ctl_t      ctl,
    input  prod_t          prods [NUM_LANES],
    output logic [S_W-1:0] s
);

    localparam int Z_W    = PROD_W + $clog2(NUM_LANES) + 1;
    localparam int IDX_W  = $clog2(TABLE_DEPTH);
    localparam int DEP_W  = $clog2(TABLE_DEPTH) + 1;
    localparam int OFF_W  = 20;
    localparam int SCL_W  = OFF_W + DEP_W;

    logic signed [Z_W-1:0] z_reg, z_next;
    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic [S_W-1:0]        s_reg;
    logic [S_W-1:0]        rom_tbl [TABLE_DEPTH];
    logic [OFF_W-1:0]      off;
    logic [SCL_W-1:0]      scaled;

    for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_tbl
        localparam logic [S_W-1:0] ENTRY = sig_entry(i, TABLE_DEPTH);
        assign rom_tbl[i] = ENTRY;
    end

    always_comb begin
        z_next = '0;
        for (int j = 0; j < NUM_LANES; j++) begin
            z_next = z_next + {{(Z_W - PROD_W){prods[j][PROD_W-1]}}, prods[j]};
        end
    end

    // z + 8.0 in Q.16, valid inside [-8,8)
    assign off    = {~z_reg[OFF_W-1], z_reg[OFF_W-2:0]};
    assign scaled = SCL_W'(off) * SCL_W'(TABLE_DEPTH);

    always_comb begin
        if (z_reg < -$signed(Z_W'(1) <<< (OFF_W - 1))) begin
            idx_next = '0;
        end else if (z_reg >= $signed(Z_W'(1) <<< (OFF_W - 1))) begin
            idx_next = IDX_W'(TABLE_DEPTH - 1);
        end else begin
            idx_next = scaled[OFF_W +: IDX_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.sum_en) begin
            z_reg <= z_next;
        end
        if (ctl.idx_en) begin
            idx_reg <= idx_next;
        end
        if (ctl.rom_en) begin
            s_reg <= rom_tbl[idx_reg];
        end
    end

    assign s = s_reg;

endmodule

// ===== hdl/lnbt_grad.sv =====
`timescale 1ns / 1ps

module lnbt_grad import lnbt_pkg::*; (
    input  logic                      aclk,
    input  grad_ctl_t                 ctl,
    input  logic [S_W-1:0]            s,
    input  logic                      label,
    output logic signed [E_W-1:0]     error,
    output logic signed [DELTA_W-1:0] delta
);

    localparam int SS_W = 2 * S_W;
    localparam int ED_W = E_W + D_W + 1;

    logic signed [E_W-1:0]     e_reg, e_next;
    logic [D_W-1:0]            d_reg;
    logic signed [DELTA_W-1:0] delta_reg;
    logic [SS_W-1:0]           ss;
    logic signed [ED_W-1:0]    ed;

    assign e_next = $signed({1'b0, s}) - (label ? $signed({1'b0, ONE_Q16}) : $signed(E_W'(0)));
    assign ss     = SS_W'(s) * SS_W'(ONE_Q16 - s);
    assign ed     = ED_W'(e_reg) * ED_W'($signed({1'b0, d_reg}));

    always_ff @(posedge aclk) begin
        if (ctl.err_en) begin
            e_reg <= e_next;
            d_reg <= ss[16 +: D_W];
        end
        if (ctl.delta_en) begin
            delta_reg <= ed[16 +: DELTA_W];
        end
    end

    assign error = e_reg;
    assign delta = delta_reg;

endmodule

// ===== hdl/logistic_neuron_batch_trainer.sv =====
`timescale 1ns / 1ps

// Single sigmoid neuron with batch gradient descent. One request is taken at a time,
// and the state sequencer walks it through the lane multiply, the lane merge, the
// table index and the registered sigmoid table read; a train request goes on through
// error and derivative, gradient scaling and accumulation, and the train request that
// closes a batch also through the two-step weight update (its 57-bit step product is
// built from two partial products). The result is loaded once the output register
// is free, and the next request is taken after that. One lane per feature plus a
// bias lane hold the weights and gradient sums. A new request is accepted while a
// result still waits on the output. learning_rate (Q0.16) sits at byte address 0
// of the APB port.
module logistic_neuron_batch_trainer import lnbt_pkg::*; #(
    parameter int NUM_FEATURES        = 3,
    parameter int SIGMOID_TABLE_DEPTH = 256
) (
    input  logic                         aclk,
    input  logic                         aresetn,

    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [APB_ADDR_W-1:0]        paddr,
    input  logic [APB_DATA_W-1:0]        pwdata,
    output logic [APB_DATA_W-1:0]        prdata,
    output logic                         pready,

    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_cmd,
    input  logic signed [FEAT_W-1:0]     s_feature_0,
    input  logic signed [FEAT_W-1:0]     s_feature_1,
    input  logic signed [FEAT_W-1:0]     s_feature_2,
    input  logic                         s_label,
    input  logic                         s_last_in_batch,

    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [S_W-1:0]               m_prediction,
    output logic signed [E_W-1:0]        m_error,
    output logic                         m_weights_updated,
    output logic signed [W_W-1:0]        m_weight_out_0,
    output logic signed [W_W-1:0]        m_weight_out_1,
    output logic signed [W_W-1:0]        m_weight_out_2,
    output logic signed [W_W-1:0]        m_bias_out
);

    localparam int NUM_LANES = NUM_FEATURES + 1;

    typedef enum logic [10:0] {
        ST_IDLE  = 11'b000_0000_0001,
        ST_MUL   = 11'b000_0000_0010,
        ST_SUM   = 11'b000_0000_0100,
        ST_IDX   = 11'b000_0000_1000,
        ST_ROM   = 11'b000_0001_0000,
        ST_ERR   = 11'b000_0010_0000,
        ST_DELTA = 11'b000_0100_0000,
        ST_ACC   = 11'b000_1000_0000,
        ST_UPD1  = 11'b001_0000_0000,
        ST_UPD2  = 11'b010_0000_0000,
        ST_DONE  = 11'b100_0000_0000
    } state_t;

    state_t state_reg, state_next;

    logic [LR_W-1:0]          lr_reg;
    logic                     cmd_reg;
    logic                     label_reg;
    logic                     last_reg;
    logic signed [FEAT_W-1:0] x_reg [MAX_FEATURES];

    logic                     m_valid_reg;
    logic [S_W-1:0]           pred_reg;
    logic signed [E_W-1:0]    err_reg;
    logic                     upd_reg;
    logic signed [W_W-1:0]    wout_reg [MAX_FEATURES];
    logic signed [W_W-1:0]    bout_reg;

    logic                     out_load;
    logic                     cfg_wr;
    lane_ctl_t                lane_ctl;
    eval_ctl_t                eval_ctl;
    grad_ctl_t                grad_ctl;
    prod_t                    prods [NUM_LANES];
    logic signed [W_W-1:0]    lane_w [NUM_LANES];
    logic signed [W_W-1:0]    cur_w [MAX_FEATURES];
    logic [S_W-1:0]           s_val;
    logic signed [E_W-1:0]    e_val;
    logic signed [DELTA_W-1:0] delta_val;

    // config port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_LR);

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_LR) begin
            prdata = {{(APB_DATA_W - LR_W){1'b0}}, lr_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lr_reg <= LR_RESET;
        end else if (cfg_wr) begin
            lr_reg <= pwdata[LR_W-1:0];
        end
    end

    // sequencer
    assign s_ready  = (state_reg == ST_IDLE);
    assign out_load = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (s_valid) state_next = ST_MUL;
            ST_MUL:   state_next = ST_SUM;
            ST_SUM:   state_next = ST_IDX;
            ST_IDX:   state_next = ST_ROM;
            ST_ROM:   state_next = (cmd_reg == CMD_PREDICT) ? ST_DONE : ST_ERR;
            ST_ERR:   state_next = ST_DELTA;
            ST_DELTA: state_next = ST_ACC;
            ST_ACC:   state_next = last_reg ? ST_UPD1 : ST_DONE;
            ST_UPD1:  state_next = ST_UPD2;
            ST_UPD2:  state_next = ST_DONE;
            ST_DONE:  if (out_load) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign lane_ctl.mul_en    = (state_reg == ST_MUL);
    assign lane_ctl.acc_en    = (state_reg == ST_ACC);
    assign lane_ctl.upd_lo_en = (state_reg == ST_UPD1);
    assign lane_ctl.upd_en    = (state_reg == ST_UPD2);
    assign eval_ctl.sum_en    = (state_reg == ST_SUM);
    assign eval_ctl.idx_en    = (state_reg == ST_IDX);
    assign eval_ctl.rom_en    = (state_reg == ST_ROM);
    assign grad_ctl.err_en    = (state_reg == ST_ERR);
    assign grad_ctl.delta_en  = (state_reg == ST_DELTA);

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            cmd_reg   <= s_cmd;
            label_reg <= s_label;
            last_reg  <= s_last_in_batch;
            x_reg[0]  <= s_feature_0;
            x_reg[1]  <= s_feature_1;
            x_reg[2]  <= s_feature_2;
        end
    end

    // lanes: features, then bias with a unit input
    for (genvar j = 0; j < NUM_LANES; j++) begin : g_lane
        logic signed [FEAT_W-1:0] lane_x;
        if (j < NUM_FEATURES) begin : g_feat
            assign lane_x = x_reg[j];
        end else begin : g_bias
            assign lane_x = FEAT_W'(1);
        end
        lnbt_lane u_lane (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctl     (lane_ctl),
            .x       (lane_x),
            .delta   (delta_val),
            .lr      (lr_reg),
            .prod    (prods[j]),
            .weight  (lane_w[j])
        );
    end

    for (genvar j = 0; j < MAX_FEATURES; j++) begin : g_wout
        if (j < NUM_FEATURES) begin : g_used
            assign cur_w[j] = lane_w[j];
        end else begin : g_unused
            assign cur_w[j] = '0;
        end
    end

    lnbt_eval #(
        .NUM_LANES   (NUM_LANES),
        .TABLE_DEPTH (SIGMOID_TABLE_DEPTH)
    ) u_eval (
        .aclk  (aclk),
        .ctl   (eval_ctl),
        .prods (prods),
        .s     (s_val)
    );

    lnbt_grad u_grad (
        .aclk  (aclk),
        .ctl   (grad_ctl),
        .s     (s_val),
        .label (label_reg),
        .error (e_val),
        .delta (delta_val)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            pred_reg    <= s_val;
            err_reg     <= (cmd_reg == CMD_TRAIN) ? e_val : '0;
            upd_reg     <= (cmd_reg == CMD_TRAIN) && last_reg;
            wout_reg[0] <= cur_w[0];
            wout_reg[1] <= cur_w[1];
            wout_reg[2] <= cur_w[2];
            bout_reg    <= lane_w[NUM_FEATURES];
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_prediction      = pred_reg;
    assign m_error           = err_reg;
    assign m_weights_updated = upd_reg;
    assign m_weight_out_0    = wout_reg[0];
    assign m_weight_out_1    = wout_reg[1];
    assign m_weight_out_2    = wout_reg[2];
    assign m_bias_out        = bout_reg;

endmodule
